/* sv/crash_fall_detector_unit_assert.svh */
// ----------------------------------------------------------------------------
// Crash and fall detector assertion macros
// Shared concurrent check forms for the detector's own control logic.
// ----------------------------------------------------------------------------
`ifndef CRASH_FALL_DETECTOR_UNIT_ASSERT_SVH
`define CRASH_FALL_DETECTOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CFD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("crash_fall_detector_unit: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define CFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("crash_fall_detector_unit: next-cycle check failed");

`endif

/* sv/cfd_pkg.sv */
// ----------------------------------------------------------------------------
// cfd_pkg
// Types, codes and constant tables of the crash and fall detector.
// ----------------------------------------------------------------------------
package cfd_pkg;

    localparam int MUL_W     = 17;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int PITCH_LIM = 11520;
    localparam int ATAN_N    = 24;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SQRT,
        S_CORDIC,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        J_DX,
        J_DY,
        J_DZ,
        J_THR,
        J_Y,
        J_Z,
        J_ALPHA
    } t_job;

    typedef enum logic [1:0] {
        ST_NONE  = 2'd0,
        ST_FALL  = 2'd1,
        ST_CRASH = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        CFG_CRASH_THR  = 3'd0,
        CFG_SAFE_MIN   = 3'd1,
        CFG_SAFE_MAX   = 3'd2,
        CFG_ALPHA      = 3'd3,
        CFG_FALL_SAMP  = 3'd4,
        CFG_FALL_MIN   = 3'd5,
        CFG_CRASH_HOLD = 3'd6
    } t_cfg_idx;

    // atan(2^-i) in 1/32768 degree
    function automatic logic [21:0] atan_val(input logic [4:0] idx);
        logic [21:0] v;
        case (idx)
            5'd0:  v = 22'd1474560;
            5'd1:  v = 22'd870484;
            5'd2:  v = 22'd459940;
            5'd3:  v = 22'd233473;
            5'd4:  v = 22'd117189;
            5'd5:  v = 22'd58652;
            5'd6:  v = 22'd29333;
            5'd7:  v = 22'd14667;
            5'd8:  v = 22'd7334;
            5'd9:  v = 22'd3667;
            5'd10: v = 22'd1833;
            5'd11: v = 22'd917;
            5'd12: v = 22'd458;
            5'd13: v = 22'd229;
            5'd14: v = 22'd115;
            5'd15: v = 22'd57;
            5'd16: v = 22'd29;
            5'd17: v = 22'd14;
            5'd18: v = 22'd7;
            5'd19: v = 22'd4;
            5'd20: v = 22'd2;
            5'd21: v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

/* sv/crash_fall_detector_unit.sv */
// ----------------------------------------------------------------------------
// crash_fall_detector_unit
// Crash and fall detection from accelerometer samples with timestamps.
// ----------------------------------------------------------------------------
// One transaction in carries a sample (x, y, z in 1/2048 g) and a millisecond
// timestamp; one transaction out carries the status (none, fall, crash), the
// squared change against the previous sample and the filtered pitch in
// 1/128 degree. The block works on one sample at a time. Most of its work
// falls to the single bit-serial multiplier, which forms the three squared
// deltas, the squared threshold, y^2, z^2 and the filter product in turn,
// each as a start, a shift over the 17-bit multiplier and a done; then the
// square root runs one result bit per cycle and the CORDIC one iteration
// per cycle. The very first sample skips the filter product and an
// all-zero sample skips the CORDIC, so those finish sooner.
// A finished result sits in the output register, so the next sample is taken
// while it waits; only the final commit waits for that register to free up.
// Configuration is a plain write port and is meant to be written while idle.
// ----------------------------------------------------------------------------
`include "crash_fall_detector_unit_assert.svh"

module crash_fall_detector_unit #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // sample channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [15:0] i_accel_x,
    input  logic signed [15:0] i_accel_y,
    input  logic signed [15:0] i_accel_z,
    input  logic [31:0]        i_time_ms,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_status,
    output logic [33:0]        o_delta_sq,
    output logic signed [14:0] o_pitch_filtered,
    // configuration write port
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data
);

    localparam int IW = $clog2(CORDIC_STEPS + 1);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [15:0] r_crash_thr;
    logic [13:0] r_safe_min;
    logic [13:0] r_safe_max;
    logic [8:0]  r_alpha;
    logic [7:0]  r_fall_samp;
    logic [15:0] r_fall_min;
    logic [15:0] r_crash_hold_ms;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crash_thr     <= 16'd10240;
            r_safe_min      <= 14'd7040;
            r_safe_max      <= 14'd11520;
            r_alpha         <= 9'd77;
            r_fall_samp     <= 8'd3;
            r_fall_min      <= 16'd3000;
            r_crash_hold_ms <= 16'd10000;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cfd_pkg::CFG_CRASH_THR:  r_crash_thr     <= i_cfg_data;
                cfd_pkg::CFG_SAFE_MIN:   r_safe_min      <= i_cfg_data[13:0];
                cfd_pkg::CFG_SAFE_MAX:   r_safe_max      <= i_cfg_data[13:0];
                cfd_pkg::CFG_ALPHA:      r_alpha         <= i_cfg_data[8:0];
                cfd_pkg::CFG_FALL_SAMP:  r_fall_samp     <= i_cfg_data[7:0];
                cfd_pkg::CFG_FALL_MIN:   r_fall_min      <= i_cfg_data;
                cfd_pkg::CFG_CRASH_HOLD: r_crash_hold_ms <= i_cfg_data;
                default: ; // drop writes beyond the register list
            endcase
        end
    end

    // ------------------------------------------------------------------
    // sequencer state and working registers
    // ------------------------------------------------------------------
    cfd_pkg::t_state r_state, n_state;
    cfd_pkg::t_job   r_job, n_job;
    logic            r_mbusy, n_mbusy;

    logic signed [15:0] r_x, r_y, r_z;
    logic [31:0]        r_t;

    logic [33:0]        r_dsum;
    logic [31:0]        r_thr2;
    logic [31:0]        r_sqv;      // radicand, then remainder
    logic [31:0]        r_res;
    logic [31:0]        r_bit;
    logic signed [26:0] r_cx, r_cy;
    logic signed [23:0] r_ang;
    logic [IW-1:0]      r_i;
    logic [22:0]        r_fprod;

    // detector state kept across samples
    logic signed [15:0] r_px, r_py, r_pz;
    logic               r_prev_valid;
    logic signed [14:0] r_pstate;
    logic               r_pitch_valid;
    logic [33:0]        r_last_dsq;
    logic               r_crash_hold;
    logic [31:0]        r_crash_start;
    logic [7:0]         r_fall_cnt;
    logic [31:0]        r_fall_start;
    logic               r_fall_sv;

    // output register
    logic               r_ov;
    logic [1:0]         r_ostatus;
    logic [33:0]        r_odsq;
    logic signed [14:0] r_opitch;

    // ------------------------------------------------------------------
    // multiplier operands
    // ------------------------------------------------------------------
    logic signed [16:0] w_dx, w_dy, w_dz, w_ye, w_ze;
    logic [16:0]        w_adx, w_ady, w_adz, w_ay, w_az;
    logic signed [15:0] w_pd;
    logic [15:0]        w_apd;
    logic [8:0]         w_alpha_sat;
    logic [16:0]        w_ma, w_mb;
    logic               w_mstart;
    logic               w_mdone;
    logic [33:0]        w_prod;

    assign w_dx  = {r_x[15], r_x} - {r_px[15], r_px};
    assign w_dy  = {r_y[15], r_y} - {r_py[15], r_py};
    assign w_dz  = {r_z[15], r_z} - {r_pz[15], r_pz};
    assign w_ye  = {r_y[15], r_y};
    assign w_ze  = {r_z[15], r_z};
    assign w_adx = w_dx[16] ? 17'(-w_dx) : 17'(w_dx);
    assign w_ady = w_dy[16] ? 17'(-w_dy) : 17'(w_dy);
    assign w_adz = w_dz[16] ? 17'(-w_dz) : 17'(w_dz);
    assign w_ay  = w_ye[16] ? 17'(-w_ye) : 17'(w_ye);
    assign w_az  = w_ze[16] ? 17'(-w_ze) : 17'(w_ze);

    assign w_alpha_sat = r_alpha[8] ? 9'd256 : r_alpha;

    always_comb begin
        case (r_job)
            cfd_pkg::J_DX:    begin w_ma = w_adx; w_mb = w_adx; end
            cfd_pkg::J_DY:    begin w_ma = w_ady; w_mb = w_ady; end
            cfd_pkg::J_DZ:    begin w_ma = w_adz; w_mb = w_adz; end
            cfd_pkg::J_THR:   begin w_ma = {1'b0, r_crash_thr}; w_mb = {1'b0, r_crash_thr}; end
            cfd_pkg::J_Y:     begin w_ma = w_ay;  w_mb = w_ay;  end
            cfd_pkg::J_Z:     begin w_ma = w_az;  w_mb = w_az;  end
            cfd_pkg::J_ALPHA: begin w_ma = {8'd0, w_alpha_sat}; w_mb = {1'b0, w_apd}; end
            default:          begin w_ma = '0;    w_mb = '0;    end
        endcase
    end

    assign w_mstart = (r_state == cfd_pkg::S_MUL) && !r_mbusy;

    cfd_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mstart),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .o_done  (w_mdone),
        .o_prod  (w_prod)
    );

    // ------------------------------------------------------------------
    // square root step, CORDIC step, pitch and filter arithmetic
    // ------------------------------------------------------------------
    logic [31:0]        w_trial;
    logic               w_take;
    logic [31:0]        w_res_n;
    logic               w_sqrt_last;
    logic signed [26:0] w_sx, w_sy;
    logic signed [23:0] w_atan;
    logic               w_cord_last;
    logic signed [23:0] w_angr;
    logic signed [15:0] w_pr;
    logic signed [14:0] w_p;
    logic signed [24:0] w_sd;
    logic signed [16:0] w_fq;
    logic signed [16:0] w_fv;
    logic signed [14:0] w_pnew;

    assign w_trial     = r_res + r_bit;
    assign w_take      = (r_sqv >= w_trial);
    assign w_res_n     = w_take ? ((r_res >> 1) + r_bit) : (r_res >> 1);
    assign w_sqrt_last = (r_bit == 32'd1);

    assign w_sx        = r_cy >>> r_i;
    assign w_sy        = r_cx >>> r_i;
    assign w_atan      = {2'b00, cfd_pkg::atan_val(5'(r_i))};
    assign w_cord_last = (r_i == IW'(CORDIC_STEPS - 1));

    // round the angle to 1/128 degree and clamp
    assign w_angr = r_ang + 24'sd128;
    assign w_pr   = 16'(w_angr >>> 8);
    always_comb begin
        if (w_pr > cfd_pkg::PITCH_LIM) begin
            w_p = 15'(cfd_pkg::PITCH_LIM);
        end else if (w_pr < -cfd_pkg::PITCH_LIM) begin
            w_p = 15'(-cfd_pkg::PITCH_LIM);
        end else begin
            w_p = 15'(w_pr);
        end
    end

    assign w_pd  = {w_p[14], w_p} - {r_pstate[14], r_pstate};
    assign w_apd = w_pd[15] ? 16'(-w_pd) : 16'(w_pd);

    // low-pass step: pitch += floor((alpha * diff + 128) / 256)
    assign w_sd = w_pd[15] ? -$signed({2'b00, r_fprod}) : $signed({2'b00, r_fprod});
    assign w_fq = 17'((w_sd + 25'sd128) >>> 8);
    assign w_fv = {{2{r_pstate[14]}}, r_pstate} + w_fq;
    always_comb begin
        if (!r_pitch_valid) begin
            w_pnew = w_p;
        end else if (w_fv > cfd_pkg::PITCH_LIM) begin
            w_pnew = 15'(cfd_pkg::PITCH_LIM);
        end else if (w_fv < -cfd_pkg::PITCH_LIM) begin
            w_pnew = 15'(-cfd_pkg::PITCH_LIM);
        end else begin
            w_pnew = 15'(w_fv);
        end
    end

    // ------------------------------------------------------------------
    // crash and fall decision
    // ------------------------------------------------------------------
    logic [13:0] w_absp;
    logic        w_unsafe;
    logic        w_cand;
    logic [1:0]  w_status;
    logic        w_hold_n;
    logic [31:0] w_cstart_n;
    logic [7:0]  w_fcnt_n;
    logic [31:0] w_fstart_n;
    logic        w_fsv_n;
    logic        w_commit;

    assign w_absp   = w_pnew[14] ? 14'(-w_pnew) : 14'(w_pnew);
    assign w_unsafe = !((w_absp >= r_safe_min) && (w_absp <= r_safe_max));
    assign w_cand   = r_prev_valid && (r_dsum > {2'b00, r_thr2});

    always_comb begin
        w_status   = cfd_pkg::ST_NONE;
        w_hold_n   = r_crash_hold;
        w_cstart_n = r_crash_start;
        w_fcnt_n   = r_fall_cnt;
        w_fstart_n = r_fall_start;
        w_fsv_n    = r_fall_sv;
        // hold an earlier crash until its time runs out
        if (r_crash_hold) begin
            if ((r_t - r_crash_start) < {16'd0, r_crash_hold_ms}) begin
                w_status = cfd_pkg::ST_CRASH;
            end else begin
                w_hold_n = 1'b0;
            end
        end
        if (w_status == cfd_pkg::ST_NONE && w_cand && w_unsafe) begin
            w_hold_n   = 1'b1;
            w_cstart_n = r_t;
            w_status   = cfd_pkg::ST_CRASH;
        end
        // track the fall only when no crash is shown
        if (w_status == cfd_pkg::ST_NONE) begin
            if (w_unsafe) begin
                if (r_fall_cnt == 8'd0) begin
                    w_fstart_n = r_t;
                    w_fsv_n    = 1'b1;
                end
                if (r_fall_cnt != 8'd255) begin
                    w_fcnt_n = r_fall_cnt + 8'd1;
                end
            end else begin
                w_fcnt_n = 8'd0;
                w_fsv_n  = 1'b0;
            end
            if (w_fcnt_n >= r_fall_samp && w_fsv_n &&
                (r_t - w_fstart_n) >= {16'd0, r_fall_min}) begin
                w_status = cfd_pkg::ST_FALL;
            end
        end
    end

    assign w_commit = (r_state == cfd_pkg::S_DONE) && (!r_ov || !i_out_stall);

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cfd_pkg::S_IDLE;
            r_job   <= cfd_pkg::J_DX;
            r_mbusy <= 1'b0;
        end else begin
            r_state <= n_state;
            r_job   <= n_job;
            r_mbusy <= n_mbusy;
        end
    end

    always_comb begin
        n_state = r_state;
        n_job   = r_job;
        n_mbusy = r_mbusy;
        case (r_state)
            cfd_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = cfd_pkg::S_MUL;
                    n_job   = cfd_pkg::J_DX;
                end
            end
            cfd_pkg::S_MUL: begin
                if (w_mstart) begin
                    n_mbusy = 1'b1;
                end else if (w_mdone) begin
                    n_mbusy = 1'b0;
                    if (r_job == cfd_pkg::J_Z) begin
                        n_state = cfd_pkg::S_SQRT;
                    end else if (r_job == cfd_pkg::J_ALPHA) begin
                        n_state = cfd_pkg::S_DONE;
                    end else begin
                        n_job = cfd_pkg::t_job'(r_job + 3'd1);
                    end
                end
            end
            cfd_pkg::S_SQRT: begin
                if (w_sqrt_last) begin
                    if (w_res_n == 32'd0 && r_x == 16'sd0) begin
                        // zero vector: skip the rotation, pitch is zero
                        n_state = r_pitch_valid ? cfd_pkg::S_MUL : cfd_pkg::S_DONE;
                        n_job   = cfd_pkg::J_ALPHA;
                    end else begin
                        n_state = cfd_pkg::S_CORDIC;
                    end
                end
            end
            cfd_pkg::S_CORDIC: begin
                if (w_cord_last) begin
                    n_state = r_pitch_valid ? cfd_pkg::S_MUL : cfd_pkg::S_DONE;
                    n_job   = cfd_pkg::J_ALPHA;
                end
            end
            cfd_pkg::S_DONE: begin
                if (w_commit) begin
                    n_state = cfd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cfd_pkg::S_IDLE;
            end
        endcase
    end

    // working datapath
    always_ff @(posedge i_clk) begin
        if (r_state == cfd_pkg::S_IDLE && i_in_valid) begin
            r_x <= i_accel_x;
            r_y <= i_accel_y;
            r_z <= i_accel_z;
            r_t <= i_time_ms;
        end
        if (r_state == cfd_pkg::S_MUL && w_mdone) begin
            case (r_job)
                cfd_pkg::J_DX:    r_dsum  <= w_prod;
                cfd_pkg::J_DY:    r_dsum  <= r_dsum + w_prod;
                cfd_pkg::J_DZ:    r_dsum  <= r_dsum + w_prod;
                cfd_pkg::J_THR:   r_thr2  <= w_prod[31:0];
                cfd_pkg::J_Y:     r_sqv   <= w_prod[31:0];
                cfd_pkg::J_Z:     r_sqv   <= r_sqv + w_prod[31:0];
                cfd_pkg::J_ALPHA: r_fprod <= w_prod[22:0];
                default: ;
            endcase
            if (r_job == cfd_pkg::J_Z) begin
                r_res <= 32'd0;
                r_bit <= 32'h4000_0000;
            end
        end
        // one root bit per cycle
        if (r_state == cfd_pkg::S_SQRT) begin
            if (w_take) begin
                r_sqv <= r_sqv - w_trial;
            end
            r_res <= w_res_n;
            r_bit <= r_bit >> 2;
            if (w_sqrt_last) begin
                r_cx  <= $signed({3'b000, w_res_n[15:0], 8'd0});
                r_cy  <= -$signed({{3{r_x[15]}}, r_x, 8'd0});
                r_ang <= '0;
                r_i   <= '0;
            end
        end
        // one vectoring iteration per cycle
        if (r_state == cfd_pkg::S_CORDIC) begin
            if (!r_cy[26]) begin
                r_cx  <= r_cx + w_sx;
                r_cy  <= r_cy - w_sy;
                r_ang <= r_ang + w_atan;
            end else begin
                r_cx  <= r_cx - w_sx;
                r_cy  <= r_cy + w_sy;
                r_ang <= r_ang - w_atan;
            end
            r_i <= r_i + 1'b1;
        end
    end

    // detector state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px          <= '0;
            r_py          <= '0;
            r_pz          <= '0;
            r_prev_valid  <= 1'b0;
            r_pstate      <= '0;
            r_pitch_valid <= 1'b0;
            r_last_dsq    <= '0;
            r_crash_hold  <= 1'b0;
            r_crash_start <= '0;
            r_fall_cnt    <= '0;
            r_fall_start  <= '0;
            r_fall_sv     <= 1'b0;
            r_ov          <= 1'b0;
        end else begin
            if (w_commit) begin
                r_px          <= r_x;
                r_py          <= r_y;
                r_pz          <= r_z;
                r_prev_valid  <= 1'b1;
                r_pstate      <= w_pnew;
                r_pitch_valid <= 1'b1;
                if (r_prev_valid) begin
                    r_last_dsq <= r_dsum;
                end
                r_crash_hold  <= w_hold_n;
                r_crash_start <= w_cstart_n;
                r_fall_cnt    <= w_fcnt_n;
                r_fall_start  <= w_fstart_n;
                r_fall_sv     <= w_fsv_n;
                r_ov          <= 1'b1;
            end else if (r_ov && !i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_ostatus <= w_status;
            r_odsq    <= r_prev_valid ? r_dsum : r_last_dsq;
            r_opitch  <= w_pnew;
        end
    end

    assign o_in_stall       = (r_state != cfd_pkg::S_IDLE);
    assign o_out_valid      = r_ov;
    assign o_status         = r_ostatus;
    assign o_delta_sq       = r_odsq;
    assign o_pitch_filtered = r_opitch;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `CFD_ASSERT_NEXT(a_accept_leaves_idle, i_in_valid && !o_in_stall, r_state == cfd_pkg::S_MUL && r_job == cfd_pkg::J_DX)
    `CFD_ASSERT_NOW(a_mul_done_in_mul, w_mdone, r_state == cfd_pkg::S_MUL && r_mbusy)
    `CFD_ASSERT_NEXT(a_commit_shows_result, w_commit, r_ov && r_state == cfd_pkg::S_IDLE)
    `CFD_ASSERT_NOW(a_status_code, r_ov, r_ostatus != 2'd3)

endmodule

/* sv/cfd_mul.sv */
// ----------------------------------------------------------------------------
// cfd_mul
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module cfd_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [cfd_pkg::MUL_W-1:0]     i_a,
    input  logic [cfd_pkg::MUL_W-1:0]     i_b,
    output logic                          o_done,
    output logic [cfd_pkg::PROD_W-1:0]    o_prod
);

    localparam int CW = $clog2(cfd_pkg::MUL_W + 1);

    logic [cfd_pkg::MUL_W-1:0]  r_a;
    logic [cfd_pkg::PROD_W-1:0] r_b;
    logic [cfd_pkg::PROD_W-1:0] r_acc;
    logic [CW-1:0]              r_cnt;
    logic                       r_busy;
    logic                       r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CW'(cfd_pkg::MUL_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // shift the operands one bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= {{cfd_pkg::MUL_W{1'b0}}, i_b};
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_a[0]) begin
                r_acc <= r_acc + r_b;
            end
            r_a <= r_a >> 1;
            r_b <= r_b << 1;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

/* tb/sv/cfd_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cfd_checker
// Watches both channels of the crash and fall detector, predicts every result
// from the accepted samples and the register writes, and counts mismatches.
// ----------------------------------------------------------------------------
module cfd_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic signed [15:0] i_accel_x,
    input  logic signed [15:0] i_accel_y,
    input  logic signed [15:0] i_accel_z,
    input  logic [31:0]        i_time_ms,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [1:0]         i_status,
    input  logic [33:0]        i_delta_sq,
    input  logic signed [14:0] i_pitch_filtered,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    output int                 o_errors,
    output int                 o_pending
);

    typedef struct {
        logic [1:0]         status;
        logic [33:0]        delta_sq;
        logic signed [14:0] pitch;
    } t_verdict;

    t_verdict verdict_q[$];

    // shadow registers
    logic [15:0] thr_r;
    logic [13:0] smin_r, smax_r;
    logic [8:0]  alpha_r;
    logic [7:0]  fsamp_r;
    logic [15:0] fmin_r, hold_r;

    // shadow state
    longint      px, py, pz;
    bit          prev_ok, pitch_ok, hold_on, fstart_ok;
    longint      pitch_acc;
    logic [33:0] dsq_last;
    logic [31:0] crash_t0, fall_t0;
    int          fcount;

    int atan_lut[16] = '{1474560, 870484, 459940, 233473, 117189, 58652, 29333,
                         14667, 7334, 3667, 1833, 917, 458, 229, 115, 57};

    function automatic longint fshr(longint v, int k);
        return v >>> k;
    endfunction

    function automatic longint int_sqrt(longint v);
        longint r;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            if ((r + (64'sd1 <<< b)) * (r + (64'sd1 <<< b)) <= v)
                r = r + (64'sd1 <<< b);
        end
        return r;
    endfunction

    function automatic longint pitch_of(longint x, longint y, longint z);
        longint r, cx, cy, ang, ddx, ddy, p;
        r = int_sqrt(y * y + z * z);
        if (r == 0 && x == 0) return 0;
        cx = r * 256;
        cy = -x * 256;
        ang = 0;
        for (int i = 0; i < 16; i++) begin
            ddx = fshr(cy, i);
            ddy = fshr(cx, i);
            if (cy >= 0) begin
                cx += ddx; cy -= ddy; ang += atan_lut[i];
            end else begin
                cx -= ddx; cy += ddy; ang -= atan_lut[i];
            end
        end
        p = fshr(ang + 128, 8);
        if (p > cfd_pkg::PITCH_LIM) p = cfd_pkg::PITCH_LIM;
        if (p < -cfd_pkg::PITCH_LIM) p = -cfd_pkg::PITCH_LIM;
        return p;
    endfunction

    function automatic t_verdict detect_step(longint x, longint y, longint z,
                                             logic [31:0] t);
        t_verdict         v;
        bit               cand, unsafe;
        longint           p, a, nv, absp;
        cfd_pkg::t_status st;
        cand = 0;
        st = cfd_pkg::ST_NONE;
        if (prev_ok) begin
            dsq_last = 34'((x - px) * (x - px) + (y - py) * (y - py)
                           + (z - pz) * (z - pz));
            cand = longint'(dsq_last) > longint'(thr_r) * longint'(thr_r);
        end
        px = x; py = y; pz = z; prev_ok = 1;
        p = pitch_of(x, y, z);
        if (!pitch_ok) begin
            pitch_acc = p;
            pitch_ok = 1;
        end else begin
            a = (alpha_r > 256) ? 256 : alpha_r;
            nv = pitch_acc + fshr(a * (p - pitch_acc) + 128, 8);
            if (nv > cfd_pkg::PITCH_LIM) nv = cfd_pkg::PITCH_LIM;
            if (nv < -cfd_pkg::PITCH_LIM) nv = -cfd_pkg::PITCH_LIM;
            pitch_acc = nv;
        end
        absp = pitch_acc < 0 ? -pitch_acc : pitch_acc;
        unsafe = !(absp >= smin_r && absp <= smax_r);
        if (hold_on) begin
            if (32'(t - crash_t0) < hold_r) st = cfd_pkg::ST_CRASH;
            else hold_on = 0;
        end
        if (st == cfd_pkg::ST_NONE && cand && unsafe) begin
            hold_on = 1;
            crash_t0 = t;
            st = cfd_pkg::ST_CRASH;
        end
        if (st == cfd_pkg::ST_NONE) begin
            if (unsafe) begin
                if (fcount == 0) begin
                    fall_t0 = t;
                    fstart_ok = 1;
                end
                if (fcount < 255) fcount++;
            end else begin
                fcount = 0;
                fstart_ok = 0;
            end
            if (fcount >= fsamp_r && fstart_ok && 32'(t - fall_t0) >= fmin_r)
                st = cfd_pkg::ST_FALL;
        end
        v.status = st;
        v.delta_sq = dsq_last;
        v.pitch = 15'(pitch_acc);
        return v;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        o_errors++;
    endtask

    initial o_errors = 0;
    assign o_pending = verdict_q.size();

    always @(posedge i_clk) begin
        t_verdict w;
        if (!i_rst_n) begin
            thr_r = 10240; smin_r = 7040; smax_r = 11520; alpha_r = 77;
            fsamp_r = 3; fmin_r = 3000; hold_r = 10000;
            px = 0; py = 0; pz = 0; prev_ok = 0; pitch_ok = 0; pitch_acc = 0;
            dsq_last = 0; hold_on = 0; crash_t0 = 0; fcount = 0; fall_t0 = 0;
            fstart_ok = 0;
            verdict_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (cfd_pkg::t_cfg_idx'(i_cfg_idx))
                    cfd_pkg::CFG_CRASH_THR:  thr_r = i_cfg_data;
                    cfd_pkg::CFG_SAFE_MIN:   smin_r = i_cfg_data[13:0];
                    cfd_pkg::CFG_SAFE_MAX:   smax_r = i_cfg_data[13:0];
                    cfd_pkg::CFG_ALPHA:      alpha_r = i_cfg_data[8:0];
                    cfd_pkg::CFG_FALL_SAMP:  fsamp_r = i_cfg_data[7:0];
                    cfd_pkg::CFG_FALL_MIN:   fmin_r = i_cfg_data;
                    cfd_pkg::CFG_CRASH_HOLD: hold_r = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                verdict_q.push_back(detect_step(i_accel_x, i_accel_y, i_accel_z,
                                                i_time_ms));
            if (i_out_valid && !i_out_stall) begin
                if (verdict_q.size() == 0) begin
                    report_mismatch("unexpected transaction", 0, 0);
                end else begin
                    w = verdict_q.pop_front();
                    if (i_status !== w.status)
                        report_mismatch("status", i_status, w.status);
                    if (i_delta_sq !== w.delta_sq)
                        report_mismatch("delta_sq", i_delta_sq, w.delta_sq);
                    if (i_pitch_filtered !== w.pitch)
                        report_mismatch("pitch", i_pitch_filtered, w.pitch);
                end
            end
        end
    end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives samples and register writes into the crash and fall detector and
// gives the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CYCLE_LIMIT = 1500000;

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               in_valid = 0;
    logic               in_stall;
    logic signed [15:0] ax = 0, ay = 0, az = 0;
    logic [31:0]        tms = 0;
    logic               out_valid;
    logic               out_stall = 0;
    logic [1:0]         status;
    logic [33:0]        delta_sq;
    logic signed [14:0] pitch_f;
    logic               cfg_we = 0;
    logic [2:0]         cfg_idx = 0;
    logic [15:0]        cfg_data = 0;
    int                 errors, pending;
    int                 cycles = 0;
    int                 send_idle = 0, recv_idle = 0;
    logic [31:0]        clock_ms = 0;

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    crash_fall_detector_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_accel_x(ax), .i_accel_y(ay), .i_accel_z(az), .i_time_ms(tms),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_status(status), .o_delta_sq(delta_sq), .o_pitch_filtered(pitch_f),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    cfd_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_accel_x(ax), .i_accel_y(ay), .i_accel_z(az), .i_time_ms(tms),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_status(status), .i_delta_sq(delta_sq), .i_pitch_filtered(pitch_f),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    // Abort a hung run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[crash_fall_detector_unit] ERROR");
            $finish;
        end
    end

    // Stall the result channel at random; zero percent means always take it.
    always @(negedge i_clk) begin
        out_stall <= (recv_idle > 0) && ($urandom_range(99) < recv_idle);
    end

    // Push one sample transaction, idling first at the sender's rate.
    // Valid stays up after the accepting edge; the next call, an idle cycle
    // or the drain drops or replaces it at the following falling edge.
    task automatic send_sample(int x, int y, int z, logic [31:0] t);
        cfg_we <= 0;
        while (send_idle > 0 && $urandom_range(99) < send_idle) begin
            in_valid <= 0;
            @(negedge i_clk);
        end
        ax <= 16'(x); ay <= 16'(y); az <= 16'(z); tms <= t;
        in_valid <= 1;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Write one register; the caller guarantees the block is idle.
    // The enable stays up until the next sample clears it.
    task automatic write_reg(cfd_pkg::t_cfg_idx idx, int val);
        cfg_we <= 1; cfg_idx <= idx; cfg_data <= 16'(val);
        @(negedge i_clk);
    endtask

    // Wait for every expected result, then let the pipeline settle.
    task automatic drain;
        in_valid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
    endtask

    // Random sample: mostly realistic motion, some full-range noise.
    task automatic random_sample;
        int mode;
        int x, y, z;
        mode = $urandom_range(9);
        if (mode < 2) begin
            x = $urandom; y = $urandom; z = $urandom;
        end else if (mode < 5) begin
            // tilted on its side: large x, small y/z
            x = ($urandom_range(1) ? 1 : -1) * $signed($urandom_range(1500, 2100));
            y = $signed($urandom_range(600)) - 300;
            z = $signed($urandom_range(600)) - 300;
        end else if (mode < 6) begin
            // impact spike
            x = $signed($urandom_range(40000)) - 20000;
            y = $signed($urandom_range(40000)) - 20000;
            z = $signed($urandom_range(40000)) - 20000;
        end else begin
            x = $signed($urandom_range(800)) - 400;
            y = $signed($urandom_range(800)) - 400;
            z = 2048 + $signed($urandom_range(400)) - 200;
        end
        if ($urandom_range(19) == 0) clock_ms = $urandom;
        else clock_ms = clock_ms + $urandom_range(1500);
        send_sample(x, y, z, clock_ms);
    endtask

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // Directed: reset values, zero vector, extremes, time wrap, holds.
        send_sample(0, 0, 0, 0);
        send_sample(32767, 32767, 32767, 10);
        send_sample(-32768, -32768, -32768, 20);
        send_sample(-32768, 0, 0, 5000);
        send_sample(32767, 0, 0, 9000);
        send_sample(0, 32767, 0, 9100);
        send_sample(0, 0, -32768, 30000);
        send_sample(2048, 0, 0, 31000);
        send_sample(2048, 0, 0, 33000);
        send_sample(2048, 0, 0, 36500);
        send_sample(2048, 0, 0, 32'hFFFF_FFF0);
        send_sample(2048, 0, 0, 32'h0000_1000);
        drain();
        write_reg(cfd_pkg::CFG_CRASH_THR, 0);
        write_reg(cfd_pkg::CFG_SAFE_MIN, 0);
        write_reg(cfd_pkg::CFG_SAFE_MAX, 0);
        write_reg(cfd_pkg::CFG_ALPHA, 256);
        write_reg(cfd_pkg::CFG_FALL_SAMP, 1);
        write_reg(cfd_pkg::CFG_FALL_MIN, 0);
        write_reg(cfd_pkg::CFG_CRASH_HOLD, 0);
        send_sample(100, 0, 2048, 40000);
        send_sample(100, 0, 2048, 40001);
        send_sample(-2000, 0, 100, 40002);
        send_sample(2000, 50, 100, 40003);
        drain();
        write_reg(cfd_pkg::CFG_ALPHA, 511);
        write_reg(cfd_pkg::CFG_CRASH_HOLD, 65535);
        write_reg(cfd_pkg::CFG_FALL_SAMP, 255);
        write_reg(cfd_pkg::CFG_FALL_MIN, 65535);
        write_reg(cfd_pkg::CFG_SAFE_MAX, 16383);
        send_sample(-2000, 0, 0, 50000);
        send_sample(2000, 0, 0, 50001);
        send_sample(0, 0, 0, 120000);
        drain();

        // Random phases with varied settings and idling patterns.
        for (int ph = 0; ph < 9; ph++) begin
            send_idle = (ph < 3) ? 23 : (ph < 6) ? 0 : 0;
            recv_idle = (ph < 3) ? 45 : 0;
            if (ph >= 3 && ph < 6) begin
                send_idle = 45; recv_idle = 23;
            end
            if (ph == 0 || ph == 8) begin
                write_reg(cfd_pkg::CFG_CRASH_THR, 10240);
                write_reg(cfd_pkg::CFG_SAFE_MIN, 7040);
                write_reg(cfd_pkg::CFG_SAFE_MAX, 11520);
                write_reg(cfd_pkg::CFG_ALPHA, 77);
                write_reg(cfd_pkg::CFG_FALL_SAMP, 3);
                write_reg(cfd_pkg::CFG_FALL_MIN, 3000);
                write_reg(cfd_pkg::CFG_CRASH_HOLD, 10000);
            end else begin
                write_reg(cfd_pkg::CFG_CRASH_THR, int'($urandom_range(65535)));
                write_reg(cfd_pkg::CFG_SAFE_MIN, int'($urandom_range(11520)));
                write_reg(cfd_pkg::CFG_SAFE_MAX, int'($urandom_range(16383)));
                write_reg(cfd_pkg::CFG_ALPHA, int'($urandom_range(511)));
                write_reg(cfd_pkg::CFG_FALL_SAMP, int'($urandom_range(255)));
                write_reg(cfd_pkg::CFG_FALL_MIN, int'($urandom_range(65535)));
                write_reg(cfd_pkg::CFG_CRASH_HOLD, int'($urandom_range(65535)));
            end
            repeat (92) random_sample();
            drain();
        end

        if (errors == 0)
            $display("[crash_fall_detector_unit] OK");
        else
            $display("[crash_fall_detector_unit] ERROR");
        $finish;
    end

endmodule
